// ===== src/tcc_pkg.sv =====
// shared types and constants of the transitive closure connectivity unit
package tcc_pkg;

   localparam int DEFAULT_MAX_VERTICES = 64;
   localparam int VERTEX_W = 6;
   localparam int COUNT_W = 7;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

   typedef struct packed {
      logic valid;
      logic connected;
   } result_type;

endpackage

// ===== src/tcc_row_mem.sv =====
// reachability row memory, one write port and one registered read port
module tcc_row_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] row_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= row_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tcc_sequencer.sv =====
// edge insert, closure and check sequencer around the row memory
module tcc_sequencer #(
   parameter int MAX_VERTICES = tcc_pkg::DEFAULT_MAX_VERTICES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tcc_pkg::VERTEX_W-1:0]     req_from_vertex,
   input  logic [tcc_pkg::VERTEX_W-1:0]     req_to_vertex,
   input  logic                             req_both_ways,
   input  logic                             req_last_edge,
   input  logic [tcc_pkg::COUNT_W-1:0]      vertex_count,
   input  logic                             result_free,
   output tcc_pkg::result_type              result,
   output logic                             mem_rd_en,
   output logic [$clog2(MAX_VERTICES)-1:0]  mem_rd_addr,
   input  logic [MAX_VERTICES-1:0]          mem_rd_data,
   output logic                             mem_wr_en,
   output logic [$clog2(MAX_VERTICES)-1:0]  mem_wr_addr,
   output logic [MAX_VERTICES-1:0]          mem_wr_data
);

   import tcc_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int NW = $clog2(MAX_VERTICES + 1);
   localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;
   localparam int ROW = MAX_VERTICES;

   typedef enum logic [3:0] {
      CLEAR,
      LOAD,
      EDGE_FWD,
      EDGE_REV,
      PIVOT_RD,
      PIVOT_LD,
      ROW_SWEEP,
      CHECK_RD,
      CHECK_SWEEP,
      DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [AW-1:0]    pivot_ff, pivot_in;
   logic [AW-1:0]    from_ff, from_in;
   logic [AW-1:0]    to_ff, to_in;
   logic             fwd_ok_ff, fwd_ok_in;
   logic             rev_ok_ff, rev_ok_in;
   logic             last_ff, last_in;
   logic             ok_ff, ok_in;
   logic [ROW-1:0]   pivot_row_ff, pivot_row_in;

   logic [CW-1:0]    count_ext;
   logic [CW-1:0]    count_clamped;
   logic [NW-1:0]    active_n;
   logic [CW-1:0]    from_ext;
   logic [CW-1:0]    to_ext;
   logic [AW-1:0]    req_from_idx;
   logic [AW-1:0]    req_to_idx;
   logic             edge_ok;
   logic             accept;
   logic             row_last;
   logic             pivot_last;
   logic             row_in_range;
   logic [ROW:0]     mask_wide;
   logic [ROW-1:0]   col_mask;
   logic [ROW-1:0]   diag_bit;
   logic             row_full;
   state_type        after_edge;

   assign count_ext = CW'(vertex_count);
   assign count_clamped = (count_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : count_ext;
   assign active_n = count_clamped[NW-1:0];

   assign from_ext = CW'(req_from_vertex);
   assign to_ext = CW'(req_to_vertex);
   assign req_from_idx = from_ext[AW-1:0];
   assign req_to_idx = to_ext[AW-1:0];
   assign edge_ok = (from_ext < count_clamped) && (to_ext < count_clamped);

   assign req_stall = (state_ff != LOAD);
   assign accept = req_valid && (state_ff == LOAD);

   assign row_last = (NW'(addr_ff) + NW'(1)) == active_n;
   assign pivot_last = (NW'(pivot_ff) + NW'(1)) == active_n;
   assign row_in_range = NW'(addr_ff) < active_n;

   assign mask_wide = ((ROW + 1)'(1) << active_n) - (ROW + 1)'(1);
   assign col_mask = mask_wide[ROW-1:0];
   assign diag_bit = ROW'(1) << addr_ff;
   assign row_full = ((mem_rd_data | diag_bit) & col_mask) == col_mask;

   // after an edge: back to loading, or start the closure (straight to the check when the count is zero)
   always_comb begin
      if (!last_ff) begin
         after_edge = LOAD;
      end else if (active_n == '0) begin
         after_edge = CHECK_RD;
      end else begin
         after_edge = PIVOT_RD;
      end
   end

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff;
      pivot_in = pivot_ff;
      from_in = from_ff;
      to_in = to_ff;
      fwd_ok_in = fwd_ok_ff;
      rev_ok_in = rev_ok_ff;
      last_in = last_ff;
      ok_in = ok_ff;
      pivot_row_in = pivot_row_ff;

      mem_rd_en = 1'b0;
      mem_rd_addr = addr_ff;
      mem_wr_en = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = '0;

      result.valid = 1'b0;
      result.connected = ok_ff;

      case (state_ff)
         CLEAR: begin
            mem_wr_en = 1'b1;
            if (addr_ff == AW'(MAX_VERTICES - 1)) begin
               addr_in = '0;
               state_in = LOAD;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         LOAD: begin
            if (accept) begin
               mem_rd_en = 1'b1;
               mem_rd_addr = req_from_idx;
               from_in = req_from_idx;
               to_in = req_to_idx;
               fwd_ok_in = edge_ok;
               rev_ok_in = edge_ok && req_both_ways && (req_from_vertex != req_to_vertex);
               last_in = req_last_edge;
               state_in = EDGE_FWD;
            end
         end
         EDGE_FWD: begin
            mem_wr_en = fwd_ok_ff;
            mem_wr_addr = from_ff;
            mem_wr_data = mem_rd_data | (ROW'(1) << to_ff);
            mem_rd_en = rev_ok_ff;
            mem_rd_addr = to_ff;
            state_in = rev_ok_ff ? EDGE_REV : after_edge;
            pivot_in = '0;
         end
         EDGE_REV: begin
            mem_wr_en = 1'b1;
            mem_wr_addr = to_ff;
            mem_wr_data = mem_rd_data | (ROW'(1) << from_ff);
            state_in = after_edge;
            pivot_in = '0;
         end
         PIVOT_RD: begin
            mem_rd_en = 1'b1;
            mem_rd_addr = pivot_ff;
            state_in = PIVOT_LD;
         end
         PIVOT_LD: begin
            pivot_row_in = mem_rd_data;
            mem_rd_en = 1'b1;
            mem_rd_addr = '0;
            addr_in = '0;
            state_in = ROW_SWEEP;
         end
         ROW_SWEEP: begin
            mem_wr_en = mem_rd_data[pivot_ff];
            mem_wr_addr = addr_ff;
            mem_wr_data = mem_rd_data | pivot_row_ff;
            if (!row_last) begin
               mem_rd_en = 1'b1;
               mem_rd_addr = addr_ff + AW'(1);
               addr_in = addr_ff + AW'(1);
            end else if (pivot_last) begin
               state_in = CHECK_RD;
            end else begin
               pivot_in = pivot_ff + AW'(1);
               state_in = PIVOT_RD;
            end
         end
         CHECK_RD: begin
            mem_rd_en = 1'b1;
            mem_rd_addr = '0;
            addr_in = '0;
            ok_in = 1'b1;
            state_in = CHECK_SWEEP;
         end
         CHECK_SWEEP: begin
            // check the row and clear it for the next graph
            mem_wr_en = 1'b1;
            mem_wr_addr = addr_ff;
            mem_wr_data = '0;
            ok_in = ok_ff && (!row_in_range || row_full);
            if (addr_ff == AW'(MAX_VERTICES - 1)) begin
               addr_in = '0;
               state_in = DONE;
            end else begin
               mem_rd_en = 1'b1;
               mem_rd_addr = addr_ff + AW'(1);
               addr_in = addr_ff + AW'(1);
            end
         end
         DONE: begin
            if (result_free) begin
               result.valid = 1'b1;
               state_in = LOAD;
            end
         end
         default: begin
            state_in = CLEAR;
            addr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         addr_ff <= '0;
         pivot_ff <= '0;
         last_ff <= 1'b0;
         ok_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         pivot_ff <= pivot_in;
         last_ff <= last_in;
         ok_ff <= ok_in;
      end
      from_ff <= from_in;
      to_ff <= to_in;
      fwd_ok_ff <= fwd_ok_in;
      rev_ok_ff <= rev_ok_in;
      pivot_row_ff <= pivot_row_in;
   end

endmodule

// ===== src/transitive_closure_connectivity_unit.sv =====
// top level of the transitive closure connectivity unit
//
//  channel | ports                                   | direction | transaction
//  req     | req_valid, req_stall, req_* fields      | in        | one directed edge
//  rsp     | rsp_valid, rsp_stall, rsp_* field       | out       | one connectivity flag
//  csr     | csr_wr_en, csr_wr_data                  | in        | vertex count write
//
// an edge is a row read-modify-write, plus a second one with both_ways on two distinct in-range vertices
// the last edge starts the closure over the first n rows, one pivot at a time and one row per cycle
// through the memory port, then a check and clear of every row, where n is the clamped vertex count
// after reset, all MAX_VERTICES rows are cleared before the first edge is accepted
// a waiting result is held in the output register while the next graph loads
module transitive_closure_connectivity_unit #(
   parameter int MAX_VERTICES = tcc_pkg::DEFAULT_MAX_VERTICES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tcc_pkg::VERTEX_W-1:0] req_from_vertex,
   input  logic [tcc_pkg::VERTEX_W-1:0] req_to_vertex,
   input  logic                         req_both_ways,
   input  logic                         req_last_edge,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_strongly_connected,
   input  logic                         csr_wr_en,
   input  logic [tcc_pkg::COUNT_W-1:0]  csr_wr_data
);

   import tcc_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);

   logic [COUNT_W-1:0]    vertex_count_ff, vertex_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_connected_ff, rsp_connected_in;
   logic                  result_free;
   result_type            result;

   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   logic [MAX_VERTICES-1:0] mem_rd_data;
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [MAX_VERTICES-1:0] mem_wr_data;

   assign vertex_count_in = csr_wr_en ? csr_wr_data : vertex_count_ff;

   assign result_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = result.valid || (rsp_valid_ff && rsp_stall);
   assign rsp_connected_in = result.valid ? result.connected : rsp_connected_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         vertex_count_ff <= vertex_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_connected_ff <= rsp_connected_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_strongly_connected = rsp_connected_ff;

   tcc_sequencer #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_sequencer (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_from_vertex(req_from_vertex),
      .req_to_vertex(req_to_vertex),
      .req_both_ways(req_both_ways),
      .req_last_edge(req_last_edge),
      .vertex_count(vertex_count_ff),
      .result_free(result_free),
      .result(result),
      .mem_rd_en(mem_rd_en),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data),
      .mem_wr_en(mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data)
   );

   tcc_row_mem #(
      .DEPTH(MAX_VERTICES),
      .WIDTH(MAX_VERTICES)
   ) u_row_mem (
      .clock(clock),
      .rd_en(mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data),
      .wr_en(mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data)
   );

endmodule

// ===== tb/tb_transitive_closure_connectivity_unit.sv =====
// self-checking testbench of the transitive closure connectivity unit
module tb_transitive_closure_connectivity_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import tcc_pkg::*;

   localparam int MAXV = DEFAULT_MAX_VERTICES;
   localparam int LIMIT = 2_000_000;
   localparam int LONG_HOLD = 2500;
   localparam int RANDOM_EDGES = 600;

   typedef bit [VERTEX_W-1:0] vertex_type;

   typedef struct packed {
      vertex_type a;
      vertex_type b;
      bit         both;
   } link_type;

   class connectivity_scoreboard;
      bit [MAXV-1:0]    reach [MAXV];
      bit [COUNT_W-1:0] count;
      bit               expected_flags [$];
      int               errors;

      function new();
         count = COUNT_RESET;
         errors = 0;
         foreach (reach[r]) reach[r] = '0;
      endfunction

      function int active_count();
         return (count > MAXV) ? MAXV : int'(count);
      endfunction

      function void set_count(bit [COUNT_W-1:0] value);
         count = value;
      endfunction

      function int pending();
         return expected_flags.size();
      endfunction

      function int settle_cycles();
         int n;
         n = active_count();
         return n * (n + 2) + 2 * MAXV + 16;
      endfunction

      function bit close_graph();
         int n;
         bit [MAXV-1:0] mask;
         bit ok;
         n = active_count();
         mask = '0;
         for (int s = 0; s < n; s++) begin
            reach[s][s] = 1'b1;
            mask[s] = 1'b1;
         end
         for (int p = 0; p < n; p++)
            for (int r = 0; r < n; r++)
               if (reach[r][p]) reach[r] |= reach[p];
         ok = 1'b1;
         for (int s = 0; s < n; s++)
            if ((reach[s] & mask) != mask) ok = 1'b0;
         foreach (reach[r]) reach[r] = '0;
         return ok;
      endfunction

      function void note_edge(vertex_type a, vertex_type b, bit both, bit last);
         int n;
         n = active_count();
         if (a < n && b < n) begin
            reach[a][b] = 1'b1;
            if (both) reach[b][a] = 1'b1;
         end
         if (last) expected_flags.push_back(close_graph());
      endfunction

      function void check_flag(bit actual);
         bit predicted;
         if (expected_flags.size() == 0) begin
            $error("strongly_connected: expected none, got %0d", actual);
            errors++;
         end else begin
            predicted = expected_flags.pop_front();
            if (predicted != actual) begin
               $error("strongly_connected: expected %0d, got %0d", predicted, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [VERTEX_W-1:0] req_from_vertex;
   logic [VERTEX_W-1:0] req_to_vertex;
   logic                req_both_ways;
   logic                req_last_edge;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_strongly_connected;
   logic                csr_wr_en;
   logic [COUNT_W-1:0]  csr_wr_data;

   connectivity_scoreboard sb;
   bit no_idle = 1'b0;
   bit long_hold_request = 1'b0;
   int random_edges = 0;
   int cycle_count = 0;

   transitive_closure_connectivity_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_from_vertex       (req_from_vertex),
      .req_to_vertex         (req_to_vertex),
      .req_both_ways         (req_both_ways),
      .req_last_edge         (req_last_edge),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_strongly_connected(rsp_strongly_connected),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   always #10ns clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("tb_transitive_closure_connectivity_unit NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) sb.set_count(csr_wr_data);
         if (req_valid && !req_stall)
            sb.note_edge(req_from_vertex, req_to_vertex, req_both_ways, req_last_edge);
         if (rsp_valid && !rsp_stall) sb.check_flag(rsp_strongly_connected);
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic link_type make_link(int a, int b, int both);
      link_type l;
      l.a = vertex_type'(a);
      l.b = vertex_type'(b);
      l.both = (both != 0);
      return l;
   endfunction

   // receiver side: random stalls plus one long hold-off on request
   initial begin : receiver
      int stall_left;
      int run_left;
      stall_left = 0;
      run_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            stall_left = LONG_HOLD;
         end
         if (stall_left == 0 && run_left == 0 && !no_idle) begin
            run_left = $urandom_range(1, 16);
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (run_left > 0) run_left--;
         end
      end
   end

   task automatic send_link(vertex_type a, vertex_type b, bit both, bit last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_from_vertex <= a;
      req_to_vertex <= b;
      req_both_ways <= both;
      req_last_edge <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_count(bit [COUNT_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (sb.settle_cycles()) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // rings, trees with mostly two-way edges or random edges over a shuffled vertex order, some noise
   task automatic send_graph(int n, bit close);
      int perm [MAXV];
      link_type links [$];
      int kind;
      int j;
      int tmp;
      int drop;
      kind = $urandom_range(0, 3);
      if (n == 0) begin
         repeat ($urandom_range(1, 3))
            links.push_back(make_link($urandom_range(0, 63), $urandom_range(0, 63),
                                      $urandom_range(0, 1)));
      end else begin
         for (int i = 0; i < n; i++) perm[i] = i;
         for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
         end
         case (kind)
            0, 3: begin
               drop = -1;
               if (kind == 0 && $urandom_range(0, 2) == 0) drop = $urandom_range(0, n - 1);
               for (int i = 0; i < n; i++)
                  if (i != drop)
                     links.push_back(make_link(perm[i], perm[(i + 1) % n],
                                               $urandom_range(0, 3) == 0));
               if (kind == 3)
                  repeat ($urandom_range(1, 3))
                     links.push_back(make_link($urandom_range(0, n - 1),
                                               $urandom_range(0, n - 1),
                                               $urandom_range(0, 1)));
            end
            1: begin
               for (int i = 1; i < n; i++)
                  links.push_back(make_link(perm[i], perm[$urandom_range(0, i - 1)],
                                            $urandom_range(0, 4) != 0));
            end
            default: begin
               repeat ($urandom_range(1, 2 * n))
                  links.push_back(make_link($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                            $urandom_range(0, 1)));
            end
         endcase
      end
      if ($urandom_range(0, 9) < 3 || links.size() == 0)
         repeat ($urandom_range(1, 2))
            links.push_back(make_link($urandom_range(0, 63), $urandom_range(0, 63),
                                      $urandom_range(0, 1)));
      foreach (links[i])
         send_link(links[i].a, links[i].b, links[i].both, close && i == links.size() - 1);
      random_edges += links.size();
   endtask

   initial begin
      int r;
      int phase;
      int graphs;
      int n;
      bit [COUNT_W-1:0] value;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_from_vertex = '0;
      req_to_vertex = '0;
      req_both_ways = 1'b0;
      req_last_edge = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // full size graph at the reset count
      send_link(0, 63, 1, 0);
      send_link(63, 0, 0, 0);
      send_link(5, 5, 0, 1);
      // zero count, every edge ignored
      write_count(0);
      send_link(0, 0, 0, 0);
      send_link(63, 63, 1, 1);
      // single vertex
      write_count(1);
      send_link(0, 0, 0, 1);
      send_link(1, 0, 1, 1);
      // oversized count
      write_count(127);
      send_link(63, 0, 1, 0);
      send_link(62, 63, 0, 1);
      // three vertices: ring, two-way chain, one-way chain, out of range edge
      write_count(3);
      send_link(0, 1, 0, 0);
      send_link(1, 2, 0, 0);
      send_link(2, 0, 0, 1);
      send_link(0, 1, 1, 0);
      send_link(1, 2, 1, 1);
      send_link(0, 1, 0, 0);
      send_link(1, 2, 0, 1);
      send_link(2, 5, 1, 0);
      send_link(0, 1, 1, 0);
      send_link(1, 2, 0, 1);
      // count shrinks in the middle of a graph
      send_link(0, 1, 1, 0);
      send_link(1, 2, 0, 0);
      write_count(2);
      send_link(2, 1, 0, 1);

      random_edges = 0;
      phase = 0;
      while (random_edges < RANDOM_EDGES) begin
         r = $urandom_range(0, 99);
         if (phase == 0) value = COUNT_W'(4);
         else if (r < 8) value = COUNT_W'(64);
         else if (r < 14) value = COUNT_W'($urandom_range(65, 127));
         else if (r < 20) value = COUNT_W'($urandom_range(0, 1));
         else value = COUNT_W'($urandom_range(2, 12));
         no_idle = 1'b0;
         write_count(value);
         no_idle = (phase == 1) || ($urandom_range(0, 9) == 0);
         if (phase == 0) long_hold_request = 1'b1;
         n = (value > MAXV) ? MAXV : int'(value);
         if (phase == 0) graphs = 8;
         else if (n > 32) graphs = 1;
         else graphs = $urandom_range(3, 6);
         repeat (graphs) send_graph(n, 1'b1);
         // sometimes leave a graph open across the next count write
         if ($urandom_range(0, 9) < 3) send_graph(n, 1'b0);
         phase++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (sb.settle_cycles()) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb_transitive_closure_connectivity_unit OK");
      else
         $display("tb_transitive_closure_connectivity_unit NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/tcc_pkg.sv
src/tcc_row_mem.sv
src/tcc_sequencer.sv
src/transitive_closure_connectivity_unit.sv
tb/tb_transitive_closure_connectivity_unit.sv
